FILE: src/lifo_stack_swap_move_top_defines.svh
// ---------------------------------------------------------------------------
// lifo_stack_swap_move_top_defines.svh
// Assertion macros used by the stack block's checker.
// ---------------------------------------------------------------------------
`ifndef LIFO_STACK_SWAP_MOVE_TOP_DEFINES_SVH
`define LIFO_STACK_SWAP_MOVE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LSSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LSSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/lssm_pkg.sv
// ---------------------------------------------------------------------------
// lssm_pkg
// Types, codes and defaults shared by the stack controller and datapath.
// ---------------------------------------------------------------------------
package lssm_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int ENTRY_WIDTH_DEF = 8;
  localparam int CAP_W           = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_SWAP = 2'd2,
    FUNC_MOVE = 2'd3
  } func_t;

  // Read address select
  typedef enum logic [1:0] {
    RA_TOP  = 2'd0,
    RA_POS  = 2'd1,
    RA_PTR1 = 2'd2,
    RA_PTR2 = 2'd3
  } rsel_t;

  // Write address select
  typedef enum logic [1:0] {
    WA_COUNT = 2'd0,
    WA_POS   = 2'd1,
    WA_TOP   = 2'd2,
    WA_PTR   = 2'd3
  } wsel_t;

  // Write data select
  typedef enum logic [1:0] {
    WD_ENTRY = 2'd0,
    WD_RDATA = 2'd1,
    WD_HELD  = 2'd2
  } dsel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP_WB,
    ST_SW_HELD,
    ST_SW_WR,
    ST_SW_TOP,
    ST_MV_HELD,
    ST_MV_SHIFT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  load;
    logic  rd_en;
    rsel_t ra_sel;
    logic  we;
    wsel_t wa_sel;
    dsel_t wd_sel;
    logic  held_ld;
    logic  ptr_inc;
    logic  cnt_inc;
    logic  cnt_dec;
    logic  pop_ld;
    logic  ok_set;
    logic  fire;
  } lssm_cmd_t;

  typedef struct packed {
    func_t func;
    logic  push_ok;
    logic  pop_ok;
    logic  pos_ok;
    logic  ptr_at_top;
  } lssm_sts_t;

endpackage

FILE: src/lssm_ctrl.sv
// ---------------------------------------------------------------------------
// lssm_ctrl
// Sequencer for push, pop, swap and move-to-top over the entry memory.
// ---------------------------------------------------------------------------
module lssm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lssm_pkg::lssm_sts_t sts,
  output lssm_pkg::lssm_cmd_t cmd
);
  import lssm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cmd       = lssm_cmd_t'('0);
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_DONE;
        unique case (sts.func)
          FUNC_PUSH: begin
            if (sts.push_ok) begin
              cmd.we      = 1'b1;
              cmd.wa_sel  = WA_COUNT;
              cmd.wd_sel  = WD_ENTRY;
              cmd.cnt_inc = 1'b1;
              cmd.ok_set  = 1'b1;
            end
          end
          FUNC_POP: begin
            if (sts.pop_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.ra_sel = RA_TOP;
              cmd.ok_set = 1'b1;
              state_nxt  = ST_POP_WB;
            end
          end
          FUNC_SWAP: begin
            if (sts.pos_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.ra_sel = RA_POS;
              cmd.ok_set = 1'b1;
              state_nxt  = ST_SW_HELD;
            end
          end
          FUNC_MOVE: begin
            if (sts.pos_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.ra_sel = RA_POS;
              cmd.ok_set = 1'b1;
              state_nxt  = ST_MV_HELD;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_POP_WB: begin
        cmd.pop_ld  = 1'b1;
        cmd.cnt_dec = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_SW_HELD: begin
        cmd.held_ld = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.ra_sel  = RA_TOP;
        state_nxt   = ST_SW_WR;
      end
      ST_SW_WR: begin
        cmd.we     = 1'b1;
        cmd.wa_sel = WA_POS;
        cmd.wd_sel = WD_RDATA;
        state_nxt  = ST_SW_TOP;
      end
      ST_SW_TOP: begin
        cmd.we     = 1'b1;
        cmd.wa_sel = WA_TOP;
        cmd.wd_sel = WD_HELD;
        state_nxt  = ST_DONE;
      end
      ST_MV_HELD: begin
        cmd.held_ld = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.ra_sel  = RA_PTR1;
        state_nxt   = ST_MV_SHIFT;
      end
      ST_MV_SHIFT: begin
        cmd.we     = 1'b1;
        cmd.wa_sel = WA_PTR;
        if (sts.ptr_at_top) begin
          cmd.wd_sel = WD_HELD;
          state_nxt  = ST_DONE;
        end else begin
          // write ptr from the entry above, fetch the one after it
          cmd.wd_sel  = WD_RDATA;
          cmd.rd_en   = 1'b1;
          cmd.ra_sel  = RA_PTR2;
          cmd.ptr_inc = 1'b1;
        end
      end
      ST_DONE: begin
        cmd.fire  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: src/lssm_dpath.sv
// ---------------------------------------------------------------------------
// lssm_dpath
// Entry memory, fill count, capacity register and result registers.
// ---------------------------------------------------------------------------
module lssm_dpath #(
  parameter int DEPTH       = lssm_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = lssm_pkg::ENTRY_WIDTH_DEF,
  parameter int AW          = $clog2(DEPTH),
  parameter int CW          = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lssm_pkg::CAP_W-1:0] cfg_wdata,
  input  logic [1:0]                 in_func,
  input  logic [ENTRY_WIDTH-1:0]     in_entry_in,
  input  logic [AW-1:0]              in_pos,
  input  lssm_pkg::lssm_cmd_t        cmd,
  output lssm_pkg::lssm_sts_t        sts,
  output logic                       out_valid,
  output logic                       out_ok,
  output logic [ENTRY_WIDTH-1:0]     out_entry_out,
  output logic [CW-1:0]              out_count,
  output logic                       out_is_empty,
  output logic                       out_is_full
);
  import lssm_pkg::*;

  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  logic [ENTRY_WIDTH-1:0] mem [DEPTH];
  logic [ENTRY_WIDTH-1:0] rdata_r;
  logic [ENTRY_WIDTH-1:0] entry_r, held_r, popped_r;
  logic [AW-1:0]          pos_r, ptr_r;
  func_t                  func_r;
  logic [CW-1:0]          count_r;
  logic [CAP_W-1:0]       cap_r;
  logic                   ok_r;
  logic                   valid_r;

  logic [CW-1:0]          top_full;
  logic [AW-1:0]          top, ptr_p1, ptr_p2, raddr, waddr;
  logic [ENTRY_WIDTH-1:0] wdata;
  logic [LW-1:0]          cap_ext, lim, cnt_ext;

  assign top_full = count_r - CW'(1);
  assign top      = top_full[AW-1:0];
  assign ptr_p1   = ptr_r + AW'(1);
  assign ptr_p2   = ptr_r + AW'(2);

  // effective capacity saturates at the memory depth
  assign cap_ext = LW'(cap_r);
  assign lim     = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
  assign cnt_ext = LW'(count_r);

  assign sts.func       = func_r;
  assign sts.push_ok    = (cnt_ext < lim);
  assign sts.pop_ok     = (count_r != '0);
  assign sts.pos_ok     = (CW'(pos_r) < count_r);
  assign sts.ptr_at_top = (ptr_r == top);

  always_comb begin
    case (cmd.ra_sel)
      RA_TOP:  raddr = top;
      RA_POS:  raddr = pos_r;
      RA_PTR1: raddr = ptr_p1;
      RA_PTR2: raddr = ptr_p2;
      default: raddr = top;
    endcase
    case (cmd.wa_sel)
      WA_COUNT: waddr = count_r[AW-1:0];
      WA_POS:   waddr = pos_r;
      WA_TOP:   waddr = top;
      WA_PTR:   waddr = ptr_r;
      default:  waddr = ptr_r;
    endcase
    case (cmd.wd_sel)
      WD_ENTRY: wdata = entry_r;
      WD_RDATA: wdata = rdata_r;
      WD_HELD:  wdata = held_r;
      default:  wdata = held_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= func_t'(in_func);
      entry_r  <= in_entry_in;
      pos_r    <= in_pos;
      ptr_r    <= in_pos;
      ok_r     <= 1'b0;
      popped_r <= '0;
    end else begin
      if (cmd.ptr_inc) ptr_r <= ptr_p1;
      if (cmd.ok_set)  ok_r <= 1'b1;
      if (cmd.pop_ld)  popped_r <= rdata_r;
    end
    if (cmd.held_ld) held_r <= rdata_r;
    if (cmd.fire) begin
      out_ok        <= ok_r;
      out_entry_out <= popped_r;
      out_count     <= count_r;
      out_is_empty  <= (count_r == '0);
      out_is_full   <= (cnt_ext >= lim);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RESET;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we)       cap_r <= cfg_wdata;
      if (cmd.cnt_inc)      count_r <= count_r + CW'(1);
      else if (cmd.cnt_dec) count_r <= count_r - CW'(1);
      valid_r <= cmd.fire;
    end
  end

  assign out_valid = valid_r;

endmodule

FILE: src/lifo_stack_swap_move_top.sv
// ---------------------------------------------------------------------------
// lifo_stack_swap_move_top
// Bounded LIFO stack with push, pop, swap-with-top and move-to-top.
// ---------------------------------------------------------------------------
// One transaction is taken at a rising edge with start high and busy low;
// busy stays high until its result appears, and the result is shown for
// exactly one cycle with out_valid high. The receiver cannot stall, so it
// must take every result in that cycle. Push and any refused operation
// are the shortest; pop takes longer, swap longer still, and move-to-top
// grows with (top - pos). The lengths are set by the entry memory with
// one read and one write port: move-to-top shifts the entries above pos
// down one per cycle, a read and a write each cycle.
// The capacity register (cfg_we / cfg_wdata) is to be written only while
// idle, which the block does not enforce; values above DEPTH act as DEPTH,
// and zero refuses every push. Memory entries need no clearing after
// reset: data read from unpushed entries is never used.
// ---------------------------------------------------------------------------
module lifo_stack_swap_move_top #(
  parameter int DEPTH       = lssm_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = lssm_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  logic [lssm_pkg::CAP_W-1:0] cfg_wdata,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_func,
  input  logic [ENTRY_WIDTH-1:0]     in_entry_in,
  input  logic [$clog2(DEPTH)-1:0]   in_pos,
  // result channel
  output logic                       out_valid,
  output logic                       out_ok,
  output logic [ENTRY_WIDTH-1:0]     out_entry_out,
  output logic [$clog2(DEPTH+1)-1:0] out_count,
  output logic                       out_is_empty,
  output logic                       out_is_full
);
  import lssm_pkg::*;

  // command from sequencer to datapath, status back
  lssm_cmd_t cmd;
  lssm_sts_t sts;

  lssm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // memory, count, capacity and result registers
  lssm_dpath #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_func       (in_func),
    .in_entry_in   (in_entry_in),
    .in_pos        (in_pos),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ok        (out_ok),
    .out_entry_out (out_entry_out),
    .out_count     (out_count),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full)
  );

endmodule

FILE: src/lssm_checker.sv
// ---------------------------------------------------------------------------
// lssm_checker
// Port-level checks on the stack block, bound to the top level.
// ---------------------------------------------------------------------------
`include "lifo_stack_swap_move_top_defines.svh"

module lssm_checker #(
  parameter int DEPTH       = lssm_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = lssm_pkg::ENTRY_WIDTH_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic                       out_ok,
  input logic [ENTRY_WIDTH-1:0]     out_entry_out,
  input logic [$clog2(DEPTH+1)-1:0] out_count
);

  // an accepted transaction holds the command side off
  `LSSM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")

  // each transaction gives one result, never two in a row
  `LSSM_ASSERT_NEXT(a_single_result, out_valid, !out_valid, "back-to-back result strobes")

  // a result only closes an outstanding transaction
  `LSSM_ASSERT_NOW(a_result_when_busy, out_valid, $past(busy), "strobe without busy")

  // popped data is zero when the operation was refused
  `LSSM_ASSERT_NOW(a_refused_zero, out_valid && !out_ok, out_entry_out == '0, "data on refusal")

  // reported count never exceeds what the memory holds
  `LSSM_ASSERT_NOW(a_count_range, out_valid, out_count <= ($clog2(DEPTH+1))'(DEPTH),
                   "count beyond depth")

endmodule

bind lifo_stack_swap_move_top lssm_checker #(
  .DEPTH       (DEPTH),
  .ENTRY_WIDTH (ENTRY_WIDTH)
) u_lssm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_ok        (out_ok),
  .out_entry_out (out_entry_out),
  .out_count     (out_count)
);
